// ===== rtl/pcf_pkg.sv =====
// Shared types and constants for the pin change timestamp framer.
package pcf_pkg;

  localparam logic [7:0]  HDR0 = 8'hAA;
  localparam logic [7:0]  HDR1 = 8'hFF;

  localparam logic [15:0] COMPARE_TOP_RST   = 16'd20000;
  localparam logic [15:0] US_PER_PERIOD_RST = 16'd10000;
  localparam logic [7:0]  CHANGE_MASK_RST   = 8'hFC;
  localparam logic [7:0]  DATA_MASK_RST     = 8'hFC;

  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    REG_COMPARE_TOP   = 2'd0,
    REG_US_PER_PERIOD = 2'd1,
    REG_CHANGE_MASK   = 2'd2,
    REG_DATA_MASK     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SLOT_HDR0  = 3'd0,
    SLOT_HDR1  = 3'd1,
    SLOT_TS3   = 3'd2,
    SLOT_TS2   = 3'd3,
    SLOT_TS1   = 3'd4,
    SLOT_TS0   = 3'd5,
    SLOT_DATA  = 3'd6,
    SLOT_SUM   = 3'd7
  } frame_slot_t;

  typedef struct packed {
    logic [15:0] compare_top;
    logic [15:0] us_per_period;
    logic [7:0]  change_mask;
    logic [7:0]  data_mask;
  } cfg_t;

  // Counter snapshot taken on a pin change
  typedef struct packed {
    logic        valid;
    logic [14:0] half;
    logic [31:0] period;
    logic [7:0]  data;
  } snap_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] prod;
    logic [14:0] half;
    logic [7:0]  data;
  } prod_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ts;
    logic [7:0]  data;
  } stamp_t;

endpackage

// ===== rtl/pcf_if.sv =====
// Request channel interfaces: pin samples in, frame bytes out.
interface pcf_pin_if;
  logic       valid;
  logic       ready;
  logic [7:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface pcf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

// ===== rtl/pin_change_timestamp_framer.sv =====
// Top level of the pin change timestamp framer.
//
//   channel      dir  payload                  handshake
//   pin_chan     in   pin_levels[7:0]          valid/ready
//   frame_chan   out  frame_byte[7:0], last    valid/ready
//   cfg          in   cfg_index[1:0], data     cfg_we, no stall
//
// One pin sample is taken per cycle while pin_chan is ready; a sample with no masked change
// yields nothing. A change yields eight bytes, one per cycle while frame_chan is ready; the
// single byte serializer takes a new frame only as the last byte of the current one goes out.
// First byte is valid once the sample has passed the snapshot, multiply, add and frame registers.
// Reset is synchronous and clears counters, previous pins, config and valid flags, not data.
// A stalled output fills the frame, add, multiply and snapshot registers before input stalls.
module pin_change_timestamp_framer
  import pcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  pcf_pin_if.sink               pin_chan,
  pcf_frame_if.source           frame_chan,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  snap_t  snap;
  logic   snap_ready;
  stamp_t stamp;
  logic   stamp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.compare_top   <= COMPARE_TOP_RST;
      cfg.us_per_period <= US_PER_PERIOD_RST;
      cfg.change_mask   <= CHANGE_MASK_RST;
      cfg.data_mask     <= DATA_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COMPARE_TOP:   cfg.compare_top   <= cfg_data;
        REG_US_PER_PERIOD: cfg.us_per_period <= cfg_data;
        REG_CHANGE_MASK:   cfg.change_mask   <= cfg_data[7:0];
        REG_DATA_MASK:     cfg.data_mask     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  pcf_track u_track (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (pin_chan.valid),
    .in_ready   (pin_chan.ready),
    .pins       (pin_chan.pin_levels),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  pcf_stamp u_stamp (
    .clk           (clk),
    .rst           (rst),
    .us_per_period (cfg.us_per_period),
    .snap          (snap),
    .snap_ready    (snap_ready),
    .stamp         (stamp),
    .stamp_ready   (stamp_ready)
  );

  pcf_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .stamp       (stamp),
    .stamp_ready (stamp_ready),
    .out_valid   (frame_chan.valid),
    .out_ready   (frame_chan.ready),
    .out_byte    (frame_chan.frame_byte),
    .out_last    (frame_chan.frame_last)
  );

endmodule

// ===== rtl/pcf_track.sv =====
// Tick counters, change detection and snapshot register.
module pcf_track
  import pcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] pins,
  output snap_t      snap,
  input  logic       snap_ready
);

  logic [15:0] sub_count;
  logic [31:0] period_count;
  logic [7:0]  previous_pins;
  logic        accept;
  logic        change;

  assign in_ready = !snap.valid || snap_ready;
  assign accept   = in_valid && in_ready;
  assign change   = |((pins ^ previous_pins) & cfg.change_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_count     <= '0;
      period_count  <= '0;
      previous_pins <= '0;
      snap.valid    <= 1'b0;
    end else begin
      if (accept) begin
        previous_pins <= pins;
        // wrap test uses >= so a lowered compare_top wraps at once
        if (sub_count >= cfg.compare_top) begin
          sub_count    <= '0;
          period_count <= period_count + 32'd1;
        end else begin
          sub_count <= sub_count + 16'd1;
        end
        snap.valid <= change;
      end else if (snap_ready) begin
        snap.valid <= 1'b0;
      end
    end
    if (accept && change) begin
      snap.half   <= sub_count[15:1];
      snap.period <= period_count;
      snap.data   <= pins & cfg.data_mask;
    end
  end

endmodule

// ===== rtl/pcf_stamp.sv =====
// Timestamp pipeline: multiply stage, then add stage.
module pcf_stamp
  import pcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] us_per_period,
  input  snap_t       snap,
  output logic        snap_ready,
  output stamp_t      stamp,
  input  logic        stamp_ready
);

  prod_t prod;
  logic  prod_ready;

  assign prod_ready = !stamp.valid || stamp_ready;
  assign snap_ready = !prod.valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid  <= 1'b0;
      stamp.valid <= 1'b0;
    end else begin
      if (snap_ready) begin
        prod.valid <= snap.valid;
      end
      if (prod_ready) begin
        stamp.valid <= prod.valid;
      end
    end
    if (snap_ready && snap.valid) begin
      // low 32 bits only: product wraps modulo 2^32
      prod.prod <= snap.period * {16'd0, us_per_period};
      prod.half <= snap.half;
      prod.data <= snap.data;
    end
    if (prod_ready && prod.valid) begin
      stamp.ts   <= prod.prod + {17'd0, prod.half};
      stamp.data <= prod.data;
    end
  end

endmodule

// ===== rtl/pcf_serial.sv =====
// Frame register and byte serializer.
module pcf_serial
  import pcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stamp_t     stamp,
  output logic       stamp_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic        busy;
  frame_slot_t slot;
  logic [31:0] ts;
  logic [7:0]  data;
  logic [7:0]  sum;
  logic [7:0]  sum_next;
  logic        out_accept;

  assign out_accept  = out_valid && out_ready;
  assign stamp_ready = !busy || (out_accept && slot == SLOT_SUM);
  assign sum_next    = stamp.ts[31:24] + stamp.ts[23:16] + stamp.ts[15:8]
                     + stamp.ts[7:0] + stamp.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= SLOT_HDR0;
    end else if (stamp_ready) begin
      busy <= stamp.valid;
      slot <= SLOT_HDR0;
    end else if (out_accept) begin
      slot <= frame_slot_t'(slot + 3'd1);
    end
    if (stamp_ready && stamp.valid) begin
      ts   <= stamp.ts;
      data <= stamp.data;
      sum  <= sum_next;
    end
  end

  always_comb begin
    case (slot)
      SLOT_HDR0: out_byte = HDR0;
      SLOT_HDR1: out_byte = HDR1;
      SLOT_TS3:  out_byte = ts[31:24];
      SLOT_TS2:  out_byte = ts[23:16];
      SLOT_TS1:  out_byte = ts[15:8];
      SLOT_TS0:  out_byte = ts[7:0];
      SLOT_DATA: out_byte = data;
      default:   out_byte = sum;
    endcase
  end

  assign out_valid = busy;
  assign out_last  = (slot == SLOT_SUM);

endmodule

// ===== rtl/pcf_checker.sv =====
// Port-level checks for the framer, bound to the top level.
module pcf_checker
  import pcf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("frame valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("frame byte changed while stalled");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("frame valid right after reset");

  a_header_follows_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid || out_byte == HDR0)
    else $error("next frame does not open with header byte");

endmodule

bind pin_change_timestamp_framer pcf_checker u_pcf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (frame_chan.valid),
  .out_ready (frame_chan.ready),
  .out_byte  (frame_chan.frame_byte),
  .out_last  (frame_chan.frame_last)
);
